>>> hdl/be3_pkg.sv
// Shared widths, register map and defaults for the 3x3 binary erosion block.
package be3_pkg;

  localparam int unsigned DEF_MAX_LINES    = 1024;
  localparam int unsigned DEF_MAX_LINE_LEN = 1024;

  localparam int unsigned MIN_EXTENT   = 3;
  localparam int unsigned RESET_EXTENT = 1024;

  localparam int unsigned EXT_W   = 11;  // width of an extent register write
  localparam int unsigned COORD_W = 10;  // out_line / out_pos width
  localparam int unsigned SURV_W  = 20;  // survivor count width

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  typedef logic [APB_ADDR_W-1:0] apb_addr_t;
  typedef logic [APB_DATA_W-1:0] apb_data_t;
  typedef logic [COORD_W-1:0]    coord_t;
  typedef logic [SURV_W-1:0]     surv_t;

  // register map, byte addresses
  localparam apb_addr_t ADDR_LINE_COUNT  = 3'd0;
  localparam apb_addr_t ADDR_LINE_LENGTH = 3'd4;

  localparam surv_t SURV_MAX = '1;

endpackage

>>> hdl/be3_pix_if.sv
// Input pixel channel: valid/ready with one binary pixel.
interface be3_pix_if;
  logic valid;
  logic ready;
  logic pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

>>> hdl/be3_res_if.sv
// Result channel: valid/ready with one eroded interior pixel and frame status.
interface be3_res_if;
  import be3_pkg::*;

  logic   valid;
  logic   ready;
  logic   eroded;
  coord_t out_line;
  coord_t out_pos;
  logic   frame_done;
  surv_t  survivors;

  modport source (output valid, output eroded, output out_line, output out_pos,
                  output frame_done, output survivors, input ready);
  modport sink   (input valid, input eroded, input out_line, input out_pos,
                  input frame_done, input survivors, output ready);
endinterface

>>> hdl/binary_erosion_3x3.sv
// Top level: streaming 3x3 square binary erosion with two line stores.
//
//  channel   | direction | payload                                          | transfer when
//  ----------+-----------+--------------------------------------------------+---------------
//  in_if     | sink      | pixel                                            | valid & ready
//  out_if    | source    | eroded, out_line, out_pos, frame_done, survivors | valid & ready
//  APB       | slave     | line_count @0x0, line_length @0x4                | psel&penable&pwrite
//
//  One pixel per clock sustained while out_if takes results. Two stages: the
//  accept stage issues the line store reads (registered read data), the second
//  stage forms the window column, writes the line stores back and loads the
//  result register. rst_n is synchronous and clears counters, window, survivor
//  count and the valid flags; the line stores hold no reset and need none. A
//  stall on out_if holds the second stage, and in_if.ready drops only when
//  both stages are full.
module binary_erosion_3x3 #(
  parameter int unsigned MAX_LINES    = be3_pkg::DEF_MAX_LINES,
  parameter int unsigned MAX_LINE_LEN = be3_pkg::DEF_MAX_LINE_LEN
) (
  input  logic                clk,
  input  logic                rst_n,
  be3_pix_if.sink             in_if,
  be3_res_if.source           out_if,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  be3_pkg::apb_addr_t  paddr,
  input  be3_pkg::apb_data_t  pwdata,
  output be3_pkg::apb_data_t  prdata,
  output logic                pready
);
  import be3_pkg::*;

  // counter widths (index < extent <= MAX) and extent widths (value <= MAX)
  localparam int unsigned LW   = $clog2(MAX_LINES);
  localparam int unsigned PW   = $clog2(MAX_LINE_LEN);
  localparam int unsigned EW_L = $clog2(MAX_LINES + 1);
  localparam int unsigned EW_P = $clog2(MAX_LINE_LEN + 1);

  localparam int unsigned RST_LINES = (RESET_EXTENT > MAX_LINES) ? MAX_LINES : RESET_EXTENT;
  localparam int unsigned RST_LEN   = (RESET_EXTENT > MAX_LINE_LEN) ? MAX_LINE_LEN
                                                                    : RESET_EXTENT;

  // out-of-range extents: below 3 acts as 3, above the maximum as the maximum
  function automatic logic [31:0] clamp_ext(input logic [EXT_W-1:0] v, input int unsigned hi);
    logic [31:0] w;
    w = 32'(v);
    if (w < 32'(MIN_EXTENT)) begin
      return 32'(MIN_EXTENT);
    end else if (w > 32'(hi)) begin
      return 32'(hi);
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [EW_L-1:0] cnt_r;
  logic [EW_P-1:0] len_r;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    unique case (paddr)
      ADDR_LINE_COUNT:  prdata = APB_DATA_W'(cnt_r);
      ADDR_LINE_LENGTH: prdata = APB_DATA_W'(len_r);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Line stores: one read at accept, one write-back when stage 1 moves on.
  // Consecutive pixels never share a position, so read and write never collide.
  // ---------------------------------------------------------------------------
  logic older_mem [MAX_LINE_LEN];
  logic newer_mem [MAX_LINE_LEN];
  logic rd_older_r;
  logic rd_newer_r;

  // ---------------------------------------------------------------------------
  // Position counters and accept stage
  // ---------------------------------------------------------------------------
  logic [PW-1:0]   pos_r, pos_nxt;
  logic [LW-1:0]   lin_r, lin_nxt;
  logic [EW_P-1:0] pos_e, npos_e, pos1;
  logic [EW_L-1:0] lin_e, lin_a, nlin_e, lin1;
  logic            pwrap, lwrap, pend;
  logic            acc_clr, acc_done, acc_int;
  logic            in_ready, in_xfer;

  // stage 1
  logic          s1_valid_r;
  logic          s1_px_r;
  logic [PW-1:0] s1_pos_r;
  logic [LW-1:0] s1_lin_r;
  logic          s1_clr_r;
  logic          s1_done_r;
  logic          s1_int_r;
  logic          s1_adv;

  // stage 2 / result register
  logic [8:0] window_r, window_nxt;
  surv_t      surv_r, surv_nxt;
  logic       keep;
  logic       out_valid_r;
  logic       out_eroded_r;
  coord_t     out_line_r;
  coord_t     out_pos_r;
  logic       out_done_r;

  always_comb begin
    // counters may sit past a freshly written extent: wrap them first
    pos_e  = EW_P'(pos_r);
    lin_e  = EW_L'(lin_r);
    pwrap  = (pos_e >= len_r);
    npos_e = pwrap ? '0 : pos_e;
    lin_a  = pwrap ? lin_e + 1'b1 : lin_e;
    lwrap  = (lin_a >= cnt_r);
    nlin_e = lwrap ? '0 : lin_a;

    // frame start clears the survivor count
    acc_clr  = lwrap | ((npos_e == '0) & (nlin_e == '0));
    acc_done = (nlin_e == cnt_r - 1'b1) & (npos_e == len_r - 1'b1);
    acc_int  = (nlin_e >= EW_L'(2)) & (npos_e >= EW_P'(2));

    // advance after this pixel
    pos1 = npos_e + 1'b1;
    lin1 = nlin_e + 1'b1;
    pend = (pos1 >= len_r);
    if (pend) begin
      pos_nxt = '0;
      lin_nxt = (lin1 >= cnt_r) ? '0 : LW'(lin1);
    end else begin
      pos_nxt = PW'(pos1);
      lin_nxt = LW'(nlin_e);
    end
  end

  assign s1_adv      = s1_valid_r & (~out_valid_r | out_if.ready);
  assign in_ready    = ~s1_valid_r | s1_adv;
  assign in_xfer     = in_if.valid & in_ready;
  assign in_if.ready = in_ready;

  // window column: two lines up in the top bit, the new pixel in the bottom bit
  always_comb begin
    window_nxt = {window_r[5:0], rd_older_r, rd_newer_r, s1_px_r};
    keep       = &window_nxt;
    surv_nxt   = s1_clr_r ? '0 : surv_r;
    if (s1_int_r && keep && (surv_nxt != SURV_MAX)) begin
      surv_nxt = surv_nxt + 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= EW_L'(RST_LINES);
      len_r       <= EW_P'(RST_LEN);
      pos_r       <= '0;
      lin_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      window_r    <= '0;
      surv_r      <= '0;
    end else begin
      if (cfg_wr) begin
        if (paddr == ADDR_LINE_COUNT) begin
          cnt_r <= EW_L'(clamp_ext(pwdata[EXT_W-1:0], MAX_LINES));
        end else if (paddr == ADDR_LINE_LENGTH) begin
          len_r <= EW_P'(clamp_ext(pwdata[EXT_W-1:0], MAX_LINE_LEN));
        end
      end
      if (in_xfer) begin
        pos_r <= pos_nxt;
        lin_r <= lin_nxt;
      end
      if (in_ready) begin
        s1_valid_r <= in_if.valid;
      end
      if (s1_adv) begin
        window_r    <= window_nxt;
        surv_r      <= surv_nxt;
        out_valid_r <= s1_int_r;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and line stores
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_px_r    <= in_if.pixel;
      s1_pos_r   <= PW'(npos_e);
      s1_lin_r   <= LW'(nlin_e);
      s1_clr_r   <= acc_clr;
      s1_done_r  <= acc_done;
      s1_int_r   <= acc_int;
      rd_older_r <= older_mem[PW'(npos_e)];
      rd_newer_r <= newer_mem[PW'(npos_e)];
    end
    if (s1_adv) begin
      older_mem[s1_pos_r] <= rd_newer_r;
      newer_mem[s1_pos_r] <= s1_px_r;
      out_eroded_r        <= keep;
      out_line_r          <= COORD_W'(s1_lin_r - 1'b1);
      out_pos_r           <= COORD_W'(s1_pos_r - 1'b1);
      out_done_r          <= s1_done_r;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.eroded     = out_eroded_r;
  assign out_if.out_line   = out_line_r;
  assign out_if.out_pos    = out_pos_r;
  assign out_if.frame_done = out_done_r;
  assign out_if.survivors  = surv_r;

endmodule

>>> tb/sv/tb_binary_erosion_3x3.sv
// Self-checking testbench for the streaming 3x3 binary erosion block.
`timescale 1ns / 1ps

module tb_binary_erosion_3x3;
  import be3_pkg::*;

  localparam int unsigned MAX_LINES    = 1024;
  localparam int unsigned MAX_LINE_LEN = 1024;
  localparam int unsigned RANDOM_ITEMS = 160;
  localparam int unsigned IDLE_PCT     = 18;
  localparam int unsigned LONG_HOLD    = 80;    // receiver hold-off, cycles
  localparam int unsigned DRAIN_CYCLES = 6;     // two pipeline stages plus margin
  localparam int unsigned LIMIT_CYCLES = 300000;

  // one eroded interior pixel as the block should report it
  typedef struct {
    logic   eroded;
    coord_t out_line;
    coord_t out_pos;
    logic   frame_done;
    surv_t  survivors;
  } erosion_t;

  logic clk = 1'b0;
  logic rst_n;

  be3_pix_if pix_if ();
  be3_res_if res_if ();

  logic      psel;
  logic      penable;
  logic      pwrite;
  apb_addr_t paddr;
  apb_data_t pwdata;
  apb_data_t prdata;
  logic      pready;

  binary_erosion_3x3 #(
    .MAX_LINES    (MAX_LINES),
    .MAX_LINE_LEN (MAX_LINE_LEN)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (pix_if),
    .out_if  (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the line stores, window, counters and
  // the effective extents. Only the monitor and the register task write it.
  // ---------------------------------------------------------------------------
  bit          older_line [MAX_LINE_LEN];
  bit          newer_line [MAX_LINE_LEN];
  logic [8:0]  window    = '0;
  int unsigned line_idx  = 0;
  int unsigned pos_idx   = 0;
  surv_t       surv_cnt  = '0;
  int unsigned cur_lines = RESET_EXTENT;
  int unsigned cur_len   = RESET_EXTENT;

  erosion_t    eroded_queue [$];   // expected results, oldest first
  bit          pixel_queue  [$];   // pixels waiting for the driver

  // stimulus-side controls, written only by the sequencing initial block
  int unsigned idle_pct  = IDLE_PCT;
  int unsigned hold_asks = 0;

  // bookkeeping
  bit          pix_done;           // input transfer at the last rising edge
  int unsigned hold_served = 0;
  int unsigned hold_left   = 0;
  int unsigned cycle_count = 0;
  int unsigned fail_count  = 0;
  int unsigned pixels_in   = 0;
  int unsigned results_in  = 0;
  int unsigned kept_seen   = 0;
  int unsigned frames_seen = 0;
  int unsigned cfg_writes  = 0;

  // A register write keeps only the low 11 bits, then pins to 3..hi.
  function automatic int unsigned effective_extent(input int unsigned raw,
                                                   input int unsigned hi);
    int unsigned v;
    v = raw & ((1 << EXT_W) - 1);
    if (v < MIN_EXTENT) return MIN_EXTENT;
    if (v > hi) return hi;
    return v;
  endfunction

  // Work out the result (if any) that one accepted pixel causes.
  task automatic erode_pixel(input logic px);
    logic     up2;
    logic     up1;
    int       lin;
    int       pos;
    erosion_t r;
    // counters may sit past a freshly shrunk extent: wrap them first
    if (pos_idx >= cur_len) begin
      pos_idx = 0;
      line_idx++;
    end
    if (line_idx >= cur_lines) begin
      line_idx = 0;
      surv_cnt = '0;
    end
    lin = line_idx;
    pos = pos_idx;
    up2 = older_line[pos];
    up1 = newer_line[pos];
    older_line[pos] = up1;
    newer_line[pos] = px;
    window = {window[5:0], up2, up1, px};
    // centre sits one line and one position behind the incoming pixel
    if (lin >= 2 && pos >= 2) begin
      r.eroded     = &window;
      r.frame_done = (lin == cur_lines - 1) && (pos == cur_len - 1);
      if (r.eroded && surv_cnt != SURV_MAX) surv_cnt++;
      r.out_line   = coord_t'(lin - 1);
      r.out_pos    = coord_t'(pos - 1);
      r.survivors  = surv_cnt;
      eroded_queue.push_back(r);
    end
    pos_idx++;
    if (pos_idx >= cur_len) begin
      pos_idx = 0;
      line_idx++;
      if (line_idx >= cur_lines) begin
        line_idx = 0;
        surv_cnt = '0;
      end
    end
  endtask

  // Pixels still owed to the current frame. A pending wrap into a new frame
  // owes that whole frame.
  function automatic int unsigned pixels_to_frame_end();
    int unsigned l;
    int unsigned p;
    l = line_idx;
    p = pos_idx;
    if (l == 0 && p == 0) return 0;
    if (p >= cur_len) begin
      p = 0;
      l++;
    end
    if (l >= cur_lines) l = 0;
    return (cur_lines - l) * cur_len - p;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: both channels sampled at the rising edge. The input transfer is
  // handled first so that a result can never overtake its own pixel.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_done <= 1'b0;
    end else begin
      pix_done <= pix_if.valid && pix_if.ready;
      if (pix_if.valid && pix_if.ready) begin
        pixels_in++;
        erode_pixel(pix_if.pixel);
      end
      if (res_if.valid && res_if.ready) begin
        results_in++;
        if (eroded_queue.size() == 0) begin
          $error("result at line %0d pos %0d with nothing expected",
                 res_if.out_line, res_if.out_pos);
          fail_count++;
        end else begin
          erosion_t e;
          e = eroded_queue.pop_front();
          if (res_if.eroded !== e.eroded) begin
            $error("eroded: expected %0d, got %0d", e.eroded, res_if.eroded);
            fail_count++;
          end
          if (res_if.out_line !== e.out_line) begin
            $error("out_line: expected %0d, got %0d", e.out_line, res_if.out_line);
            fail_count++;
          end
          if (res_if.out_pos !== e.out_pos) begin
            $error("out_pos: expected %0d, got %0d", e.out_pos, res_if.out_pos);
            fail_count++;
          end
          if (res_if.frame_done !== e.frame_done) begin
            $error("frame_done: expected %0d, got %0d", e.frame_done, res_if.frame_done);
            fail_count++;
          end
          if (res_if.survivors !== e.survivors) begin
            $error("survivors: expected %0d, got %0d", e.survivors, res_if.survivors);
            fail_count++;
          end
          if (e.eroded) kept_seen++;
          if (e.frame_done) frames_seen++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: a pixel is held until its transfer, then the next one is offered
  // or the line idles at random. Changes land on the falling edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      pix_if.valid <= 1'b0;
      pix_if.pixel <= 1'b0;
    end else if (!pix_if.valid || pix_done) begin
      if (pixel_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
        pix_if.valid <= 1'b1;
        pix_if.pixel <= pixel_queue.pop_front();
      end else begin
        pix_if.valid <= 1'b0;
        pix_if.pixel <= 1'($urandom_range(1));
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request so the
  // block fills both stages and drops in_if.ready.
  always @(negedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else if (hold_served != hold_asks) begin
      hold_served = hold_asks;
      hold_left   = LONG_HOLD - 1;
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------------

  // Block idle: nothing queued or offered, every result back, pipeline flushed.
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (pixel_queue.size() > 0 || pix_if.valid || eroded_queue.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup then access; predictor follows at the access edge.
  task automatic write_extent(input apb_addr_t addr, input int unsigned raw);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= apb_data_t'(raw);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_LINE_COUNT) cur_lines = effective_extent(raw, MAX_LINES);
    else cur_len = effective_extent(raw, MAX_LINE_LEN);
    cfg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Encode an extent, now and then with junk above bit 10 or out of range.
  function automatic int unsigned extent_code(input int unsigned target);
    case ($urandom_range(7))
      0: return target | ($urandom_range(1, (1 << 21) - 1) << EXT_W);
      1: return (target == MIN_EXTENT) ? $urandom_range(0, MIN_EXTENT - 1) : target;
      default: return target;
    endcase
  endfunction

  task automatic queue_pixels(input int unsigned count, input int unsigned density);
    repeat (count) pixel_queue.push_back($urandom_range(99) < density);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned densities [4];
    int unsigned random_items;
    int unsigned phase;
    int unsigned lines;
    int unsigned len;
    int unsigned density;
    int unsigned total;
    int unsigned part;

    densities    = '{50, 80, 93, 100};
    random_items = 0;
    phase        = 0;

    pix_if.valid = 1'b0;
    pix_if.pixel = 1'b0;
    res_if.ready = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = ADDR_LINE_COUNT;
    pwdata       = '0;
    rst_n        = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // --- directed: smallest frame, below-minimum writes pin to 3
    write_extent(ADDR_LINE_COUNT, 0);
    write_extent(ADDR_LINE_LENGTH, 2);
    repeat (9) pixel_queue.push_back(1'b1);      // lone interior pixel survives
    wait_idle();

    // 3x4 frame, junk above bit 10; zero in the last corner kills the second
    write_extent(ADDR_LINE_LENGTH, 32'hFFFF_F804);
    repeat (11) pixel_queue.push_back(1'b1);
    pixel_queue.push_back(1'b0);
    wait_idle();

    // --- extremes: tallest frame, no idling on either side, cut after 40 lines
    idle_pct = 0;
    write_extent(ADDR_LINE_COUNT, 2047);         // pins to MAX_LINES
    write_extent(ADDR_LINE_LENGTH, 3);
    queue_pixels(40 * 3, 95);
    wait_idle();
    idle_pct = IDLE_PCT;

    // widest line: line 40 lies past the new count, so a fresh frame starts;
    // a narrower line then wraps the position into line 1
    write_extent(ADDR_LINE_COUNT, 3);
    write_extent(ADDR_LINE_LENGTH, 1025);        // pins to MAX_LINE_LEN
    queue_pixels(60, 97);
    wait_idle();
    write_extent(ADDR_LINE_LENGTH, 5);
    queue_pixels(pixels_to_frame_end(), 97);
    wait_idle();

    // --- long receiver hold-off once results flow, pixels still pouring in
    write_extent(ADDR_LINE_COUNT, 6);
    write_extent(ADDR_LINE_LENGTH, 10);
    queue_pixels(60, 97);
    while (eroded_queue.size() == 0) @(posedge clk);
    hold_asks++;
    wait_idle();

    // --- random phases: whole frames with random content, some cut short by
    // a register change while the block sits idle mid-frame
    while (random_items < RANDOM_ITEMS) begin
      phase++;
      lines   = ($urandom_range(7) == 0) ? $urandom_range(8, 12) : $urandom_range(3, 7);
      len     = ($urandom_range(7) == 0) ? $urandom_range(13, 24) : $urandom_range(3, 12);
      density = densities[$urandom_range(3)];
      write_extent(ADDR_LINE_COUNT, extent_code(lines));
      write_extent(ADDR_LINE_LENGTH, extent_code(len));
      if (phase == 2) hold_asks++;
      if (phase % 3 == 1 || $urandom_range(4) == 0) begin
        // part of a frame, then a change that never widens the line: a wider
        // line would read store entries this frame never wrote
        part = $urandom_range(1, lines * len - 1);
        queue_pixels(part, density);
        wait_idle();
        case ($urandom_range(2))
          0: write_extent(ADDR_LINE_LENGTH, extent_code($urandom_range(3, len)));
          1: write_extent(ADDR_LINE_COUNT, extent_code($urandom_range(3, lines + 4)));
          default: begin
            write_extent(ADDR_LINE_COUNT, extent_code($urandom_range(3, lines + 4)));
            write_extent(ADDR_LINE_LENGTH, extent_code($urandom_range(3, len)));
          end
        endcase
        total = part + pixels_to_frame_end();
        queue_pixels(total - part, density);
      end else begin
        total = $urandom_range(1, 2) * lines * len;
        queue_pixels(total, density);
      end
      random_items += total;
      wait_idle();                               // sender pauses till all is back
    end

    wait_idle();
    $display("Covered %0d pixels over %0d random phases and %0d register writes;",
             pixels_in, phase, cfg_writes);
    $display("checked %0d results, %0d surviving, %0d frame ends.",
             results_in, kept_seen, frames_seen);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
